>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked while reset is low.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/core/tpaf_pkg.sv
// ----------------------------------------------------------------------------
// tpaf_pkg
// Types, constants and helpers for the triac phase-angle firing block.
// ----------------------------------------------------------------------------
package tpaf_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;

    localparam int unsigned DELAY_BASE = 56500;
    localparam int unsigned DELAY_STEP = 90;
    localparam int unsigned PULSE_LOW  = 'hF7;
    localparam int unsigned PULSE_HIGH = 'hFF;

    localparam logic [6:0] LEVEL_MAX    = 7'd100;
    localparam logic [2:0] MODE_MAX     = 3'd5;
    localparam logic [7:0] THRESH_RESET = 8'd100;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ZERO  = 2'd1,
        KIND_TEMP  = 2'd2,
        KIND_SPARE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_FIRE_LEVEL   = 2'd0,
        REG_CHANNEL_MODE = 2'd1,
        REG_ALARM_THRESH = 2'd2,
        REG_POWER_ENABLE = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        MODE_NONE = 3'd0,
        MODE_CH1  = 3'd1,
        MODE_CH2  = 3'd2,
        MODE_CH3  = 3'd3,
        MODE_CH12 = 3'd4,
        MODE_ALL  = 3'd5
    } mode_t;

    typedef struct packed {
        logic [6:0] fire_level;
        logic [2:0] channel_mode;
        logic [7:0] alarm_threshold;
        logic       power_enable;
    } cfg_t;

    typedef struct packed {
        logic       timer_busy;
        logic       over_temp;
        logic       buzzer_n;
        logic [2:0] gates_n;
    } status_t;

    // Gate enable mask for a channel mode, channel 1 in bit 0.
    function automatic logic [2:0] chan_enables(input logic [2:0] mode);
        logic [2:0] en;
        unique case (mode)
            MODE_CH1:  en = 3'b001;
            MODE_CH2:  en = 3'b010;
            MODE_CH3:  en = 3'b100;
            MODE_CH12: en = 3'b011;
            MODE_ALL:  en = 3'b111;
            default:   en = 3'b000;
        endcase
        return en;
    endfunction

endpackage

>>> rtl/core/tpaf_core.sv
// ----------------------------------------------------------------------------
// tpaf_core
// Phase timer, gate and alarm state; updates once per processed word.
// ----------------------------------------------------------------------------
module tpaf_core #(
    parameter int TIMER_BITS = tpaf_pkg::TIMER_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [1:0]        kind,
    input  logic [7:0]        temperature,
    input  tpaf_pkg::cfg_t    cfg,
    output tpaf_pkg::status_t status_next
);
    import tpaf_pkg::*;

    localparam logic [TIMER_BITS-1:0] PULSE_RELOAD =
        TIMER_BITS'((PULSE_HIGH << 8) | PULSE_LOW);

    logic [TIMER_BITS-1:0] tick_count_reg, tick_count_next;
    logic                  running_reg, running_next;
    logic                  pending_reg, pending_next;
    logic [2:0]            gates_reg, gates_next;
    logic                  alarm_reg, alarm_next;
    logic                  buzzer_reg, buzzer_next;

    logic [TIMER_BITS-1:0] tick_inc;
    logic [6:0]            level_sat;
    logic [TIMER_BITS-1:0] delay_load;

    assign tick_inc   = tick_count_reg + TIMER_BITS'(1);
    assign level_sat  = (cfg.fire_level > LEVEL_MAX) ? LEVEL_MAX : cfg.fire_level;
    assign delay_load = TIMER_BITS'(DELAY_BASE + DELAY_STEP * 32'(level_sat));

    always_comb begin
        tick_count_next = tick_count_reg;
        running_next    = running_reg;
        pending_next    = pending_reg;
        gates_next      = gates_reg;
        alarm_next      = alarm_reg;
        buzzer_next     = buzzer_reg;
        unique case (kind_t'(kind))
            KIND_TICK: begin
                if (running_reg) begin
                    tick_count_next = tick_inc;
                    if (tick_inc == '0) begin
                        if (pending_reg) begin
                            // fire: alarm and mode sampled here
                            pending_next    = 1'b0;
                            tick_count_next = PULSE_RELOAD;
                            if (!alarm_reg) begin
                                gates_next = gates_reg & ~chan_enables(cfg.channel_mode);
                            end
                        end else begin
                            gates_next   = 3'b111;
                            running_next = 1'b0;
                        end
                    end
                end
            end
            KIND_ZERO: begin
                if (cfg.power_enable) begin
                    tick_count_next = delay_load;
                    pending_next    = 1'b1;
                    running_next    = 1'b1;
                end
            end
            KIND_TEMP: begin
                alarm_next  = (temperature >= cfg.alarm_threshold);
                buzzer_next = (temperature <  cfg.alarm_threshold);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            running_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            gates_reg      <= 3'b111;
            alarm_reg      <= 1'b0;
            buzzer_reg     <= 1'b1;
        end else if (advance) begin
            tick_count_reg <= tick_count_next;
            running_reg    <= running_next;
            pending_reg    <= pending_next;
            gates_reg      <= gates_next;
            alarm_reg      <= alarm_next;
            buzzer_reg     <= buzzer_next;
        end
    end

    assign status_next.timer_busy = running_next;
    assign status_next.over_temp  = alarm_next;
    assign status_next.buzzer_n   = buzzer_next;
    assign status_next.gates_n    = gates_next;

endmodule

>>> rtl/core/triac_phase_angle_firing.sv
// ----------------------------------------------------------------------------
// triac_phase_angle_firing
// Three-channel phase-angle triac firing with over-temperature blocking.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake         | Contents
//  s_      | in  | s_tvalid/s_tready | tuser: kind, tdata: temperature
//  m_      | out | m_tvalid/m_tready | tdata: gates, buzzer, alarm, busy
//  apb     | in  | psel/penable      | four control registers
//
//  One word per cycle sustained while m_tready keeps the result moving;
//  a word passes through the input register, then the result register.
//  The state update sits in one short path between those two registers.
//  A stalled result holds the input register; tready drops only then.
//  Synchronous active-low reset empties both stages and restores registers.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing #(
    parameter int TIMER_BITS = tpaf_pkg::TIMER_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] temperature
    input  logic [1:0]                         s_tuser,   // [1:0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] gate1_n [1] gate2_n [2] gate3_n [3] buzzer_n [4] over_temp
    // [5] timer_busy [7:6] zero
    output logic [7:0]                         m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tpaf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [tpaf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tpaf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import tpaf_pkg::*;

    cfg_t       cfg_reg;
    reg_idx_t   reg_sel;
    logic       cfg_wr;

    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    logic [7:0] in_temp_reg;
    logic       out_valid_reg;
    status_t    out_data_reg;
    status_t    status_next;
    logic       advance;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fire_level      <= '0;
            cfg_reg.channel_mode    <= MODE_NONE;
            cfg_reg.alarm_threshold <= THRESH_RESET;
            cfg_reg.power_enable    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_FIRE_LEVEL:   cfg_reg.fire_level <= pwdata[6:0];
                REG_CHANNEL_MODE: begin
                    // drop codes without meaning
                    if (pwdata[2:0] <= MODE_MAX) begin
                        cfg_reg.channel_mode <= pwdata[2:0];
                    end
                end
                REG_ALARM_THRESH: cfg_reg.alarm_threshold <= pwdata[7:0];
                REG_POWER_ENABLE: cfg_reg.power_enable <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_FIRE_LEVEL:   prdata = APB_DATA_BITS'(cfg_reg.fire_level);
            REG_CHANNEL_MODE: prdata = APB_DATA_BITS'(cfg_reg.channel_mode);
            REG_ALARM_THRESH: prdata = APB_DATA_BITS'(cfg_reg.alarm_threshold);
            REG_POWER_ENABLE: prdata = APB_DATA_BITS'(cfg_reg.power_enable);
            default:          prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= s_tuser;
            in_temp_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= status_next;
        end
    end

    tpaf_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .kind        (in_kind_reg),
        .temperature (in_temp_reg),
        .cfg         (cfg_reg),
        .status_next (status_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

>>> rtl/core/tpaf_checker.sv
// ----------------------------------------------------------------------------
// tpaf_checker
// Port-level checks for the triac firing block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpaf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a stalled result holds its word
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // a gate can be firing only while the timer runs
    `ASSERT_CLK(a_gate_busy, aclk, aresetn, m_tvalid && (m_tdata[2:0] != 3'b111) |-> m_tdata[5])

    // buzzer sounds exactly while the alarm is set
    `ASSERT_CLK(a_buzz_alarm, aclk, aresetn, m_tvalid |-> (m_tdata[3] == !m_tdata[4]))

    // reset empties the result stage
    `ASSERT_CLK_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind triac_phase_angle_firing tpaf_checker u_tpaf_checker (.*);
